>>> rtl/fatlb_pkg.sv
package fatlb_pkg;

    // Default number of translation entries.
    localparam int TLB_ENTRIES_DEF = 16;

    localparam int ADDR_W     = 32;
    localparam int PAGE_W     = 24;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET = 5'd16;

    // Table walk masks, one per page size.
    localparam logic [PAGE_W-1:0] WALK_MASK_256 = 24'hFFF0FF;
    localparam logic [PAGE_W-1:0] WALK_MASK_4K  = 24'h0FFF0F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SIZE_4K   = 1'b0,
        CFG_ENTRIES_IN_USE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_READ,
        S_UPD
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              is_data;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] phys_page;
        logic [ADDR_W-1:0] phys_address;
        logic [CNT_W-1:0]  instr_hit_count;
        logic [CNT_W-1:0]  instr_miss_count;
        logic [CNT_W-1:0]  data_hit_count;
        logic [CNT_W-1:0]  data_miss_count;
        logic [CNT_W-1:0]  walk_count;
    } t_out_word;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic read;
        logic update;
    } t_cmd;

endpackage

>>> rtl/fatlb_ctrl.sv
module fatlb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output fatlb_pkg::t_cmd o_cmd
);
    import fatlb_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_READ;
            S_READ: n_state = S_UPD;
            S_UPD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall     = (r_state != S_IDLE);
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.lookup   = (r_state == S_LOOK);
        o_cmd.read     = (r_state == S_READ);
        // The table state is only touched once the output register can take the word.
        o_cmd.update   = (r_state == S_UPD) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_capture_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_LOOK))
        else $error("accepted word did not start a lookup");

    a_valid_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_UPD))
        else $error("output word raised outside the update step");

    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> !o_cmd.update)
        else $error("one word updated the table twice");

endmodule

>>> rtl/fatlb_dp.sv
module fatlb_dp #(
    parameter int TLB_ENTRIES = fatlb_pkg::TLB_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fatlb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fatlb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  fatlb_pkg::t_in_word                 i_in_word,
    input  fatlb_pkg::t_cmd                     i_cmd,
    output fatlb_pkg::t_out_word                o_out_word
);
    import fatlb_pkg::*;

    localparam int IW = $clog2(TLB_ENTRIES);
    localparam int LW = $clog2(TLB_ENTRIES + 1);

    // Configuration
    logic                  r_page_4k;
    logic [CFG_DATA_W-1:0] r_entries;
    logic [LW-1:0]         limit;

    // Captured access
    logic [ADDR_W-1:0] r_addr;
    logic              r_is_data;
    logic [PAGE_W-1:0] r_vpn;

    // Table
    logic [PAGE_W-1:0] r_tags    [TLB_ENTRIES];
    logic [PAGE_W-1:0] r_ppn_mem [TLB_ENTRIES];
    logic [IW-1:0]     r_rank    [TLB_ENTRIES];
    logic [IW-1:0]     n_rank    [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [TLB_ENTRIES-1:0] n_valid;
    logic [LW-1:0]     r_filled;
    logic [LW-1:0]     n_filled;

    // Lookup results
    logic          look_hit;
    logic [IW-1:0] look_found;
    logic          look_free;
    logic [IW-1:0] look_free_idx;
    logic          look_repl;
    logic [IW-1:0] look_repl_idx;
    logic          r_hit;
    logic [IW-1:0] r_found;
    logic [IW-1:0] r_found_rank;
    logic          r_use_free;
    logic          r_vict_ok;
    logic [IW-1:0] r_victim;
    logic [PAGE_W-1:0] r_ppn_rd;

    // Counters
    logic [CNT_W-1:0] r_ihit, r_imiss, r_dhit, r_dmiss, r_walks;
    logic [CNT_W-1:0] n_ihit, n_imiss, n_dhit, n_dmiss, n_walks;

    logic [PAGE_W-1:0] walk_ppn;
    logic [PAGE_W-1:0] ppn;
    logic [ADDR_W-1:0] phys_addr;
    logic              do_install;
    logic [IW-1:0]     promo_idx;
    logic [LW-1:0]     promo_old;
    logic              promo_en;
    t_out_word         r_out;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (&v) ? v : v + CNT_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_4k <= 1'b0;
            r_entries <= ENTRIES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PAGE_SIZE_4K:   r_page_4k <= i_cfg_data[0];
                CFG_ENTRIES_IN_USE: r_entries <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Usable entries, clamped to one up to the table size.
    always_comb begin
        if (r_entries == '0) begin
            limit = LW'(1);
        end else if (32'(r_entries) > TLB_ENTRIES) begin
            limit = LW'(TLB_ENTRIES);
        end else begin
            limit = LW'(r_entries);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr    <= i_in_word.address;
            r_is_data <= i_in_word.is_data;
            r_vpn     <= r_page_4k ? {4'b0, i_in_word.address[31:12]}
                                   : i_in_word.address[31:8];
        end
    end

    // Parallel tag compare; the lowest matching entry wins.
    always_comb begin
        look_hit      = 1'b0;
        look_found    = '0;
        look_free     = 1'b0;
        look_free_idx = '0;
        look_repl     = 1'b0;
        look_repl_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (LW'(r_rank[i]) < limit) && (r_tags[i] == r_vpn)) begin
                look_hit   = 1'b1;
                look_found = IW'(i);
            end
            if (!r_valid[i]) begin
                look_free     = 1'b1;
                look_free_idx = IW'(i);
            end
            if (r_valid[i] && (LW'(r_rank[i]) == limit - LW'(1))) begin
                look_repl     = 1'b1;
                look_repl_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit        <= look_hit;
            r_found      <= look_found;
            r_found_rank <= r_rank[look_found];
            r_use_free   <= (r_filled < limit) && look_free;
            if ((r_filled < limit) && look_free) begin
                r_vict_ok <= 1'b1;
                r_victim  <= look_free_idx;
            end else begin
                r_vict_ok <= look_repl;
                r_victim  <= look_repl_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_ppn_rd <= r_ppn_mem[r_found];
        end
        if (i_cmd.update && do_install) begin
            r_ppn_mem[r_victim] <= walk_ppn;
            r_tags[r_victim]    <= r_vpn;
        end
    end

    assign walk_ppn   = ~r_vpn & (r_page_4k ? WALK_MASK_4K : WALK_MASK_256);
    assign ppn        = r_hit ? r_ppn_rd : walk_ppn;
    assign phys_addr  = r_page_4k ? {ppn[19:0], r_addr[11:0]} : {ppn, r_addr[7:0]};
    assign do_install = !r_hit && r_vict_ok;

    // LRU promotion: entries more recent than the old rank age by one.
    always_comb begin
        promo_en  = r_hit || r_vict_ok;
        promo_idx = r_hit ? r_found : r_victim;
        if (r_hit) begin
            promo_old = LW'(r_found_rank);
        end else if (r_use_free) begin
            promo_old = LW'(TLB_ENTRIES);
        end else begin
            promo_old = limit - LW'(1);
        end
        n_valid  = r_valid;
        n_filled = r_filled;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (promo_en && (IW'(i) != promo_idx) && r_valid[i]
                    && (LW'(r_rank[i]) < promo_old)) begin
                n_rank[i] = r_rank[i] + IW'(1);
            end
        end
        if (promo_en) begin
            n_rank[promo_idx] = '0;
        end
        if (!r_hit && r_use_free) begin
            n_valid[r_victim] = 1'b1;
            n_filled          = r_filled + LW'(1);
        end
    end

    always_comb begin
        n_ihit  = r_ihit;
        n_imiss = r_imiss;
        n_dhit  = r_dhit;
        n_dmiss = r_dmiss;
        n_walks = r_hit ? r_walks : sat_inc(r_walks);
        case ({r_is_data, r_hit})
            2'b01:   n_ihit  = sat_inc(r_ihit);
            2'b00:   n_imiss = sat_inc(r_imiss);
            2'b11:   n_dhit  = sat_inc(r_dhit);
            default: n_dmiss = sat_inc(r_dmiss);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_filled <= '0;
            r_ihit   <= '0;
            r_imiss  <= '0;
            r_dhit   <= '0;
            r_dmiss  <= '0;
            r_walks  <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update) begin
            r_valid  <= n_valid;
            r_filled <= n_filled;
            r_ihit   <= n_ihit;
            r_imiss  <= n_imiss;
            r_dhit   <= n_dhit;
            r_dmiss  <= n_dmiss;
            r_walks  <= n_walks;
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out.hit              <= r_hit;
            r_out.phys_page        <= ppn;
            r_out.phys_address     <= phys_addr;
            r_out.instr_hit_count  <= n_ihit;
            r_out.instr_miss_count <= n_imiss;
            r_out.data_hit_count   <= n_dhit;
            r_out.data_miss_count  <= n_dmiss;
            r_out.walk_count       <= n_walks;
        end
    end

    assign o_out_word = r_out;

    a_filled_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_filled)
        else $error("fill count disagrees with valid entries");

    a_install_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_hit && r_use_free) |=> r_valid[$past(r_victim)])
        else $error("installed entry not marked valid");

    a_hit_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_hit) |=> $stable(r_walks))
        else $error("walk counted on a hit");

endmodule

>>> rtl/fully_assoc_lru_tlb.sv
// Channel  | Handshake                        | Word
// ---------+----------------------------------+--------------------------------
// input    | i_in_valid / o_in_stall          | i_in_word  (address, is_data)
// output   | o_out_valid / i_out_stall        | o_out_word (hit, pages, counts)
// config   | i_cfg_we                         | i_cfg_index, i_cfg_data
//
// An accepted word passes through four steps: capture, parallel tag compare, physical
// page memory read, then the LRU and counter update that loads the output register.
// One word is in flight at a time; the next word is taken only once the last has made its update.
// A new word is taken while the previous result still waits in the output register;
// an update waits while that register is full and stalled.
// Reset is synchronous and active low; it clears valid bits, ranks and counters.
module fully_assoc_lru_tlb #(
    parameter int TLB_ENTRIES = fatlb_pkg::TLB_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fatlb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fatlb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fatlb_pkg::t_in_word               i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fatlb_pkg::t_out_word              o_out_word
);
    import fatlb_pkg::*;

    t_cmd cmd;

    fatlb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    fatlb_dp #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_out_word  (o_out_word)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fatlb_pkg::*;

    localparam int TLB_N       = TLB_ENTRIES_DEF;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 240;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_GAP   = 8;
    localparam int POOL_MAX    = 24;

    localparam logic [31:0] WALK_256 = 32'h00FF_F0FF;
    localparam logic [31:0] WALK_4K  = 32'h000F_FF0F;

    typedef enum logic {
        ROW_ACCESS,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [4:0]  data;
        logic [31:0] address;
        logic        is_data;
        logic        typed;
        logic        hit;
        logic [23:0] page;
        logic [31:0] paddr;
    } t_dir_row;

    localparam int DIR_N = 24;

    // Expected hit, page and address are only typed in where they are obvious.
    t_dir_row dir_rows [DIR_N] = '{
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h0000_0000, 1'b0, 1'b1, 1'b0, 24'hFFF0FF,
          32'hFFF0_FF00},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h0000_00FF, 1'b1, 1'b1, 1'b1, 24'hFFF0FF,
          32'hFFF0_FFFF},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 24'h000000,
          32'h0000_00FF},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hFFFF_FF00, 1'b0, 1'b1, 1'b1, 24'h000000,
          32'h0000_0000},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h1234_5678, 1'b0, 1'b1, 1'b0, 24'hEDC0A9,
          32'hEDC0_A978},
        '{ROW_CFG,    CFG_ENTRIES_IN_USE, 5'd2,  32'h0, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h0000_0010, 1'b0, 1'b1, 1'b0, 24'hFFF0FF,
          32'hFFF0_FF10},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hFFFF_FF80, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_CFG,    CFG_ENTRIES_IN_USE, 5'd0,  32'h0, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_CFG,    CFG_ENTRIES_IN_USE, 5'd31, 32'h0, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_CFG,    CFG_PAGE_SIZE_4K,   5'd1,  32'h0, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h0000_0ABC, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 24'h000000,
          32'h0000_0FFF},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hABCD_E123, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_CFG,    CFG_ENTRIES_IN_USE, 5'd16, 32'h0, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_CFG,    CFG_PAGE_SIZE_4K,   5'd0,  32'h0, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h5555_5555, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'h1234_5600, 1'b1, 1'b0, 1'b0, 24'h0, 32'h0},
        '{ROW_ACCESS, CFG_PAGE_SIZE_4K,   5'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 24'h0, 32'h0}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    t_cfg_idx   i_cfg_index = CFG_PAGE_SIZE_4K;
    logic [4:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    // Own copy of the translation table, its settings and its counters.
    logic [23:0] tlb_tag  [TLB_N];
    logic [23:0] tlb_page [TLB_N];
    bit          tlb_vld  [TLB_N];
    int unsigned tlb_rank [TLB_N];
    int unsigned tlb_fill = 0;
    bit          tlb_4k   = 1'b0;
    logic [4:0]  tlb_limit = ENTRIES_RESET;
    logic [31:0] cnt_ih = '0, cnt_im = '0, cnt_dh = '0, cnt_dm = '0, cnt_walk = '0;

    t_out_word pending_xlat[$];

    int idle_mode    = 0;
    int fail_count   = 0;
    int results_seen = 0;
    int words_sent   = 0;
    int hits_seen    = 0;
    int cfg_writes   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    fully_assoc_lru_tlb u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < TLB_N; k++) begin
            tlb_vld[k]  = 1'b0;
            tlb_rank[k] = 0;
            tlb_tag[k]  = '0;
            tlb_page[k] = '0;
        end
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Entry e becomes most recent; valid entries that were more recent than it move down.
    function automatic void promote_entry(int e, int unsigned old_rank);
        for (int k = 0; k < TLB_N; k++) begin
            if (k != e && tlb_vld[k] && tlb_rank[k] < old_rank) begin
                tlb_rank[k]++;
            end
        end
        tlb_rank[e] = 0;
    endfunction

    function automatic t_out_word translate_access(t_in_word w);
        t_out_word   r;
        int unsigned shift;
        int unsigned limit;
        logic [31:0] vpn;
        logic [31:0] offset;
        logic [31:0] ppn;
        int          found;
        int          victim;
        shift  = tlb_4k ? 12 : 8;
        vpn    = w.address >> shift;
        offset = w.address & ((32'd1 << shift) - 32'd1);
        limit  = (tlb_limit == 0) ? 1 : (tlb_limit > TLB_N) ? TLB_N : tlb_limit;
        found  = -1;
        victim = -1;
        for (int k = 0; k < TLB_N; k++) begin
            if (found < 0 && tlb_vld[k] && tlb_rank[k] < limit && tlb_tag[k] == vpn[23:0]) begin
                found = k;
            end
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            ppn   = {8'd0, tlb_page[found]};
            promote_entry(found, tlb_rank[found]);
            if (w.is_data) cnt_dh = sat_inc(cnt_dh);
            else           cnt_ih = sat_inc(cnt_ih);
        end else begin
            r.hit    = 1'b0;
            ppn      = ~vpn & (tlb_4k ? WALK_4K : WALK_256);
            cnt_walk = sat_inc(cnt_walk);
            if (w.is_data) cnt_dm = sat_inc(cnt_dm);
            else           cnt_im = sat_inc(cnt_im);
            if (tlb_fill < limit) begin
                for (int k = 0; k < TLB_N; k++) begin
                    if (victim < 0 && !tlb_vld[k]) victim = k;
                end
            end
            if (victim >= 0) begin
                tlb_vld[victim]  = 1'b1;
                tlb_tag[victim]  = vpn[23:0];
                tlb_page[victim] = ppn[23:0];
                tlb_fill++;
                promote_entry(victim, TLB_N);
            end else begin
                // Table full up to the limit: the entry ranked last within the limit goes.
                for (int k = 0; k < TLB_N; k++) begin
                    if (victim < 0 && tlb_vld[k] && tlb_rank[k] == limit - 1) victim = k;
                end
                if (victim >= 0) begin
                    tlb_tag[victim]  = vpn[23:0];
                    tlb_page[victim] = ppn[23:0];
                    promote_entry(victim, limit - 1);
                end
            end
        end
        r.phys_page        = ppn[23:0];
        r.phys_address     = (ppn << shift) + offset;
        r.instr_hit_count  = cnt_ih;
        r.instr_miss_count = cnt_im;
        r.data_hit_count   = cnt_dh;
        r.data_miss_count  = cnt_dm;
        r.walk_count       = cnt_walk;
        return r;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            fail_count++;
        end
    endfunction

    // Offers one word, with random gaps before it, and holds it until it is taken.
    task automatic put_word(input t_in_word w, input logic typed, input logic thit,
                            input logic [23:0] tpage, input logic [31:0] tpaddr);
        t_out_word want;
        int        pct;
        pct = (idle_mode == 0) ? 33 : (idle_mode == 1) ? 64 : 0;
        if ($urandom_range(99) < pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
        want = translate_access(w);
        if (typed) begin
            want.hit          = thit;
            want.phys_page    = tpage;
            want.phys_address = tpaddr;
        end
        if (want.hit) hits_seen++;
        pending_xlat.push_back(want);
        words_sent++;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic write_reg(input t_cfg_idx idx, input logic [4:0] val);
        i_in_valid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_PAGE_SIZE_4K) tlb_4k = val[0];
        else                         tlb_limit = val;
        cfg_writes++;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : out_side
        t_out_word want;
        int        pct;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_xlat.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, actual %h",
                             $time, o_out_word);
                    fail_count++;
                end else begin
                    want = pending_xlat.pop_front();
                    check_field("hit", want.hit, o_out_word.hit);
                    check_field("phys_page", want.phys_page, o_out_word.phys_page);
                    check_field("phys_address", want.phys_address, o_out_word.phys_address);
                    check_field("instr_hit_count", want.instr_hit_count,
                                o_out_word.instr_hit_count);
                    check_field("instr_miss_count", want.instr_miss_count,
                                o_out_word.instr_miss_count);
                    check_field("data_hit_count", want.data_hit_count,
                                o_out_word.data_hit_count);
                    check_field("data_miss_count", want.data_miss_count,
                                o_out_word.data_miss_count);
                    check_field("walk_count", want.walk_count, o_out_word.walk_count);
                end
            end
            // One long hold part way through, so that the block backs up to its input.
            if (!hold_done && results_seen == HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            pct = (idle_mode == 0) ? 64 : (idle_mode == 1) ? 33 : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    initial begin : stimulus
        t_in_word    w;
        logic [31:0] page_pool [POOL_MAX];
        int          pool_n;
        logic [4:0]  lim;
        logic        pg;
        logic [31:0] offmask;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                w.address = dir_rows[r].address;
                w.is_data = dir_rows[r].is_data;
                put_word(w, dir_rows[r].typed, dir_rows[r].hit, dir_rows[r].page,
                         dir_rows[r].paddr);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       lim = 5'd16;
                1:       lim = 5'd1;
                2:       lim = 5'($urandom_range(2, 15));
                3:       lim = 5'd31;
                4:       lim = 5'd0;
                default: lim = 5'($urandom_range(0, 31));
            endcase
            pg = (ph < 2) ? ph[0] : 1'($urandom_range(1));
            write_reg(CFG_PAGE_SIZE_4K, {4'd0, pg});
            write_reg(CFG_ENTRIES_IN_USE, lim);
            idle_mode <= ph / 2;
            // A small working set of pages per phase, so that hits and evictions both occur.
            pool_n = $urandom_range(3, POOL_MAX);
            for (int k = 0; k < POOL_MAX; k++) page_pool[k] = $urandom;
            offmask = pg ? 32'h0000_0FFF : 32'h0000_00FF;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(99) < 75)
                    w.address = page_pool[$urandom_range(pool_n - 1)] ^ ($urandom & offmask);
                else
                    w.address = $urandom;
                w.is_data = $urandom_range(1);
                put_word(w, 1'b0, 1'b0, 24'h0, 32'h0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_xlat.size() != 0) @(posedge i_clk);
        repeat (4 * DRAIN_GAP) @(posedge i_clk);
        $display("Sent %0d lookups (%0d hits, %0d walks), checked %0d words, %0d reg writes.",
                 words_sent, hits_seen, cnt_walk, results_seen, cfg_writes);
        $display("Both page sizes, entry limits 0 to 31, three idle patterns, one long hold.");
        if (fail_count == 0) begin
            $display("[fully_assoc_lru_tlb] OK");
        end else begin
            $display("[fully_assoc_lru_tlb] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("[fully_assoc_lru_tlb] ERROR");
        $finish;
    end

endmodule
